@@ sv/gpr_pkg.sv @@
`default_nettype none
// ============================================================================
// gpr_pkg - shared types and constants of the gamepad poll and report block
// Register indexes, reset values, default sizes and the structs passed
// between the sequencer, the pad lanes, the report merge and the top level.
// ============================================================================
package gpr_pkg;

    localparam int TICK_W    = 16;
    localparam int ID_W      = 8;
    localparam int BTN_W     = 8;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    localparam int PAD_COUNT_DEF   = 2;
    localparam int REPORT_BITS_DEF = 8;

    localparam logic [TICK_W-1:0] POLL_INTERVAL_RST = 16'd888;
    localparam logic [ID_W-1:0]   FIRST_ID_RST      = 8'd1;
    localparam logic [ID_W-1:0]   SECOND_ID_RST     = 8'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLL_INTERVAL = 8'd0,
        CFG_FIRST_ID      = 8'd1,
        CFG_SECOND_ID     = 8'd2
    } t_cfg_idx;

    // Per-tick control from the sequencer to every pad lane
    typedef struct packed {
        logic step;   // a tick is transferred this cycle
        logic clock;  // a bit is sampled on this tick
        logic done;   // last bit sampled, reports become ready
        logic latch;  // a new poll starts, clear everything
    } t_seq_ctl;

    typedef struct packed {
        logic             valid;
        logic [ID_W-1:0]  id;
        logic [BTN_W-1:0] buttons;
    } t_report;

    typedef struct packed {
        logic             latch;
        logic             clock;
        logic             valid;
        logic [ID_W-1:0]  id;
        logic [BTN_W-1:0] buttons;
    } t_result;

endpackage
`default_nettype wire

@@ sv/gpr_poll_seq.sv @@
`default_nettype none
// ============================================================================
// gpr_poll_seq - poll counter and shift sequencer
// Counts enumerated ticks, starts a poll when the count passes the interval,
// and walks the bit position through one shift sequence.
// ============================================================================
module gpr_poll_seq #(
    parameter int REPORT_BITS = gpr_pkg::REPORT_BITS_DEF,
    parameter int SHIFT_W     = $clog2(REPORT_BITS + 1)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire logic                        i_enumerated,
    input  wire logic [gpr_pkg::TICK_W-1:0]  i_poll_interval,
    output gpr_pkg::t_seq_ctl                o_ctl,
    output logic [SHIFT_W-1:0]               o_pos
);

    localparam logic [SHIFT_W-1:0] LAST_POS = SHIFT_W'(REPORT_BITS);

    logic [gpr_pkg::TICK_W-1:0] r_tick, n_tick;
    logic [SHIFT_W-1:0]         r_pos, n_pos;
    logic                       w_clock, w_done, w_latch;

    always_comb begin
        w_clock = (r_pos != '0);
        w_done  = w_clock && (r_pos >= LAST_POS);
        w_latch = i_enumerated && (r_tick > i_poll_interval);
        n_tick  = r_tick;
        n_pos   = r_pos;
        if (w_clock) begin
            n_pos = w_done ? '0 : r_pos + SHIFT_W'(1);
        end
        if (i_enumerated) begin
            if (w_latch) begin
                n_tick = '0;
                n_pos  = SHIFT_W'(1);
            end else begin
                n_tick = r_tick + gpr_pkg::TICK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
            r_pos  <= '0;
        end else if (i_step) begin
            r_tick <= n_tick;
            r_pos  <= n_pos;
        end
    end

    assign o_ctl.step  = i_step;
    assign o_ctl.clock = w_clock;
    assign o_ctl.done  = w_done;
    assign o_ctl.latch = w_latch;
    assign o_pos       = r_pos;

endmodule
`default_nettype wire

@@ sv/gpr_pad_lane.sv @@
`default_nettype none
// ============================================================================
// gpr_pad_lane - one pad's button register and ready flag
// Samples the pad's data line at the current bit, tracks readiness of its
// report and drops the flag once the merge grants the report.
// ============================================================================
module gpr_pad_lane #(
    parameter int REPORT_BITS = gpr_pkg::REPORT_BITS_DEF,
    parameter int SHIFT_W     = $clog2(REPORT_BITS + 1)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire gpr_pkg::t_seq_ctl       i_ctl,
    input  wire logic [SHIFT_W-1:0]      i_pos,
    input  wire logic                    i_level,
    input  wire logic                    i_grant,
    output logic                         o_ready,
    output logic [REPORT_BITS-1:0]       o_buttons
);

    logic                   r_ready, n_ready;
    logic [REPORT_BITS-1:0] r_buttons, n_buttons;

    always_comb begin
        n_ready   = r_ready && !i_grant;
        n_buttons = r_buttons;
        // low level means pressed
        for (int b = 0; b < REPORT_BITS; b++) begin
            if (i_ctl.clock && (i_pos == SHIFT_W'(b + 1)) && !i_level) begin
                n_buttons[b] = 1'b1;
            end
        end
        if (i_ctl.done) begin
            n_ready = 1'b1;
        end
        if (i_ctl.latch) begin
            n_ready   = 1'b0;
            n_buttons = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready   <= 1'b0;
            r_buttons <= '0;
        end else if (i_ctl.step) begin
            r_ready   <= n_ready;
            r_buttons <= n_buttons;
        end
    end

    assign o_ready   = r_ready;
    assign o_buttons = r_buttons;

endmodule
`default_nettype wire

@@ sv/gpr_report_merge.sv @@
`default_nettype none
// ============================================================================
// gpr_report_merge - pick the first ready pad report
// Lowest-numbered ready lane wins; its id and buttons form the report and
// its grant drops that lane's ready flag.
// ============================================================================
module gpr_report_merge #(
    parameter int PAD_COUNT   = gpr_pkg::PAD_COUNT_DEF,
    parameter int REPORT_BITS = gpr_pkg::REPORT_BITS_DEF
) (
    input  wire logic                                   i_send_en,
    input  wire logic [PAD_COUNT-1:0]                   i_ready,
    input  wire logic [PAD_COUNT-1:0][REPORT_BITS-1:0]  i_buttons,
    input  wire logic [gpr_pkg::ID_W-1:0]               i_first_id,
    input  wire logic [gpr_pkg::ID_W-1:0]               i_second_id,
    output logic [PAD_COUNT-1:0]                        o_grant,
    output gpr_pkg::t_report                            o_report
);

    localparam int BW = gpr_pkg::BTN_W;

    always_comb begin
        o_grant  = '0;
        o_report = '0;
        // walk downwards so the lowest ready lane is left standing
        for (int p = PAD_COUNT - 1; p >= 0; p--) begin
            if (i_send_en && i_ready[p]) begin
                o_grant          = '0;
                o_grant[p]       = 1'b1;
                o_report.valid   = 1'b1;
                o_report.id      = (p == 0) ? i_first_id : i_second_id;
                o_report.buttons = BW'(i_buttons[p]);
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/gamepad_poll_and_report.sv @@
`default_nettype none
// ============================================================================
// gamepad_poll_and_report - shift-register gamepad poller and report sender
// One input transfer is one task tick; each tick yields one result carrying
// the latch and clock strobes for the pads and at most one pad report.
// ============================================================================
//
//  Channel  | Direction | Handshake                 | Payload
//  ---------+-----------+---------------------------+-----------------------------
//  tick in  | in        | i_in_valid / o_in_stall   | enumerated, endpoint_free,
//           |           |                           | first/second pad level
//  result   | out       | o_out_valid / i_out_stall | latch, clock, report valid,
//           |           |                           | report id, report buttons
//  config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  Throughput is one tick per clock while the queue has room; all per-tick
//  work (send, sample, count) is combinational and its result is registered
//  into a two-entry output queue.
//  The queue decouples the sides: a tick is taken while a result waits, and
//  o_in_stall rises only when both entries are full.
//  Reset (i_rst_n low, synchronous) clears counter, shift position, ready
//  flags, buttons, queue and restores the register defaults.
//  Configuration writes are always ready and take effect once registered.
//
module gamepad_poll_and_report #(
    parameter int PAD_COUNT   = gpr_pkg::PAD_COUNT_DEF,
    parameter int REPORT_BITS = gpr_pkg::REPORT_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // tick channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_enumerated,
    input  wire logic                           i_endpoint_free,
    input  wire logic                           i_first_pad_level,
    input  wire logic                           i_second_pad_level,
    // result channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_latch_pulse,
    output logic                                o_clock_pulse,
    output logic                                o_report_valid,
    output logic [gpr_pkg::ID_W-1:0]            o_report_id,
    output logic [gpr_pkg::BTN_W-1:0]           o_report_buttons,
    // configuration channel
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [gpr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [gpr_pkg::CFG_DAT_W-1:0]  i_cfg_data
);

    localparam int SHIFT_W = $clog2(REPORT_BITS + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [gpr_pkg::TICK_W-1:0] r_poll_interval;
    logic [gpr_pkg::ID_W-1:0]   r_first_id;
    logic [gpr_pkg::ID_W-1:0]   r_second_id;
    logic                       w_cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    // out-of-range indexes fall through and are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_interval <= gpr_pkg::POLL_INTERVAL_RST;
            r_first_id      <= gpr_pkg::FIRST_ID_RST;
            r_second_id     <= gpr_pkg::SECOND_ID_RST;
        end else if (w_cfg_wr) begin
            case (i_cfg_index)
                gpr_pkg::CFG_POLL_INTERVAL: begin
                    r_poll_interval <= i_cfg_data[gpr_pkg::TICK_W-1:0];
                end
                gpr_pkg::CFG_FIRST_ID: begin
                    r_first_id <= i_cfg_data[gpr_pkg::ID_W-1:0];
                end
                gpr_pkg::CFG_SECOND_ID: begin
                    r_second_id <= i_cfg_data[gpr_pkg::ID_W-1:0];
                end
                default: begin
                    r_first_id <= r_first_id;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Tick transfer and output queue occupancy
    // ------------------------------------------------------------------
    logic [1:0] r_count, n_count;
    logic       r_head;
    logic       w_push, w_pop;

    assign o_in_stall  = (r_count == 2'd2);
    assign o_out_valid = (r_count != 2'd0);
    assign w_push      = i_in_valid && !o_in_stall;
    assign w_pop       = o_out_valid && !i_out_stall;

    // ------------------------------------------------------------------
    // Sequencer, pad lanes and merge
    // ------------------------------------------------------------------
    gpr_pkg::t_seq_ctl                   w_ctl;
    gpr_pkg::t_report                    w_report;
    logic [SHIFT_W-1:0]                  w_pos;
    logic [PAD_COUNT-1:0]                w_ready;
    logic [PAD_COUNT-1:0]                w_grant;
    logic [PAD_COUNT-1:0]                w_level;
    logic [PAD_COUNT-1:0][REPORT_BITS-1:0] w_buttons;

    gpr_poll_seq #(
        .REPORT_BITS (REPORT_BITS),
        .SHIFT_W     (SHIFT_W)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_push),
        .i_enumerated    (i_enumerated),
        .i_poll_interval (r_poll_interval),
        .o_ctl           (w_ctl),
        .o_pos           (w_pos)
    );

    // pads past the first share the second pad's data line
    for (genvar p = 0; p < PAD_COUNT; p++) begin : g_lane
        assign w_level[p] = (p == 0) ? i_first_pad_level : i_second_pad_level;

        gpr_pad_lane #(
            .REPORT_BITS (REPORT_BITS),
            .SHIFT_W     (SHIFT_W)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_pos     (w_pos),
            .i_level   (w_level[p]),
            .i_grant   (w_grant[p]),
            .o_ready   (w_ready[p]),
            .o_buttons (w_buttons[p])
        );
    end

    gpr_report_merge #(
        .PAD_COUNT   (PAD_COUNT),
        .REPORT_BITS (REPORT_BITS)
    ) u_merge (
        .i_send_en   (i_enumerated && i_endpoint_free),
        .i_ready     (w_ready),
        .i_buttons   (w_buttons),
        .i_first_id  (r_first_id),
        .i_second_id (r_second_id),
        .o_grant     (w_grant),
        .o_report    (w_report)
    );

    // ------------------------------------------------------------------
    // Two-entry result queue
    // ------------------------------------------------------------------
    gpr_pkg::t_result r_q [2];
    gpr_pkg::t_result w_res;
    gpr_pkg::t_result w_head;
    logic             w_tail;

    always_comb begin
        w_res.latch   = w_ctl.latch;
        w_res.clock   = w_ctl.clock;
        w_res.valid   = w_report.valid;
        w_res.id      = w_report.id;
        w_res.buttons = w_report.buttons;
    end

    assign w_tail = r_head ^ r_count[0];
    assign n_count = r_count + {1'b0, w_push} - {1'b0, w_pop};

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[w_tail] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_head  <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_pop) begin
                r_head <= ~r_head;
            end
        end
    end

    assign w_head           = r_q[r_head];
    assign o_latch_pulse    = w_head.latch;
    assign o_clock_pulse    = w_head.clock;
    assign o_report_valid   = w_head.valid;
    assign o_report_id      = w_head.id;
    assign o_report_buttons = w_head.buttons;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_grant_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_grant))
        else $error("more than one pad report granted in one tick");

    a_latch_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_ctl.latch) |=> (w_pos == SHIFT_W'(1)))
        else $error("poll start did not restart the shift sequence at bit 0");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result queue overflowed");

    a_grant_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_grant[0] && !w_ctl.done) |=> !w_ready[0])
        else $error("granted pad report still ready on the next tick");

endmodule
`default_nettype wire

@@ test/tb_gamepad_poll_and_report.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_gamepad_poll_and_report - self-checking bench for the gamepad poller
// Feeds task ticks through the tick channel and predicts every result: latch
// and clock strobes, the shifted pad buttons and the report sent per tick.
// Results are checked field by field in order. The bench walks through
// several register settings, including the interval extremes. Both sides
// idle at random, the receiver holds off for a long stretch twice, and the
// sender pauses until the block has drained.
// ============================================================================
module tb_gamepad_poll_and_report;

    localparam int PADS          = gpr_pkg::PAD_COUNT_DEF;
    localparam int SHIFT_BITS    = gpr_pkg::REPORT_BITS_DEF;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 4;      // result is registered into the queue on the transfer
    localparam int HOLD_CYCLES   = 80;     // long receiver hold-off
    localparam int IDLE_PCT      = 9;
    localparam int CYCLE_LIMIT   = 400000;

    // Index that names no register; a write to it must change nothing
    localparam logic [gpr_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 8'hFF;

    typedef struct {
        bit enumerated;
        bit endpoint_free;
        bit first_level;
        bit second_level;
        bit after_drain;   // hold this tick back until every result is in
    } t_tick;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic                          i_clk              = 1'b0;
    logic                          i_rst_n            = 1'b0;
    logic                          i_in_valid         = 1'b0;
    logic                          i_enumerated       = 1'b0;
    logic                          i_endpoint_free    = 1'b0;
    logic                          i_first_pad_level  = 1'b1;
    logic                          i_second_pad_level = 1'b1;
    logic                          i_out_stall        = 1'b0;
    logic                          i_cfg_valid        = 1'b0;
    logic [gpr_pkg::CFG_IDX_W-1:0] i_cfg_index        = '0;
    logic [gpr_pkg::CFG_DAT_W-1:0] i_cfg_data         = '0;

    logic                      o_in_stall;
    logic                      o_out_valid;
    logic                      o_latch_pulse;
    logic                      o_clock_pulse;
    logic                      o_report_valid;
    logic [gpr_pkg::ID_W-1:0]  o_report_id;
    logic [gpr_pkg::BTN_W-1:0] o_report_buttons;
    logic                      o_cfg_ready;

    always #6 i_clk = ~i_clk;

    gamepad_poll_and_report i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_enumerated       (i_enumerated),
        .i_endpoint_free    (i_endpoint_free),
        .i_first_pad_level  (i_first_pad_level),
        .i_second_pad_level (i_second_pad_level),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_latch_pulse      (o_latch_pulse),
        .o_clock_pulse      (o_clock_pulse),
        .o_report_valid     (o_report_valid),
        .o_report_id        (o_report_id),
        .o_report_buttons   (o_report_buttons),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow of the poller: registers and per-pad state
    // ------------------------------------------------------------------
    logic [gpr_pkg::TICK_W-1:0] poll_ivl = gpr_pkg::POLL_INTERVAL_RST;
    logic [gpr_pkg::ID_W-1:0]   pad_id [0:PADS-1] =
        '{gpr_pkg::FIRST_ID_RST, gpr_pkg::SECOND_ID_RST};
    logic [gpr_pkg::TICK_W-1:0] tick_cnt = '0;
    logic [gpr_pkg::BTN_W-1:0]  pad_btn [0:PADS-1] = '{default: '0};
    bit                         pad_rdy [0:PADS-1] = '{default: 1'b0};
    logic [3:0]                 shift_pos = '0;

    t_tick            tick_q[$];         // ticks waiting to be offered
    gpr_pkg::t_result due_results[$];    // predicted results, oldest first
    t_tick            cur_tick;

    int  ticks_sent   = 0;      // tick transfers so far
    int  results_done = 0;      // result transfers so far
    int  mismatches   = 0;
    int  hold_asks    = 0;
    int  holds_done   = 0;
    int  rx_hold_left = 0;
    int  cycle_count  = 0;
    bit  steady       = 1'b0;   // suppress random idling on both sides

    // Advance the shadow by one tick and return the result it must produce.
    // Order within a tick: send from the ready flags as they stood, sample,
    // then count and possibly start a fresh poll.
    function automatic gpr_pkg::t_result poll_tick(t_tick t);
        gpr_pkg::t_result r;
        bit      lvl [0:PADS-1];
        bit      sent;
        int      bit_no;
        r      = '0;
        sent   = 1'b0;
        lvl[0] = t.first_level;
        lvl[1] = t.second_level;
        if (t.enumerated && t.endpoint_free) begin
            for (int p = 0; p < PADS; p++) begin
                if (!sent && pad_rdy[p]) begin
                    sent       = 1'b1;
                    r.valid    = 1'b1;
                    r.id       = pad_id[p];
                    r.buttons  = pad_btn[p];
                    pad_rdy[p] = 1'b0;
                end
            end
        end
        if (shift_pos != 0) begin
            bit_no = (shift_pos - 1) & 7;
            for (int p = 0; p < PADS; p++) begin
                // low level on the data line means pressed
                if (!lvl[p]) pad_btn[p][bit_no] = 1'b1;
            end
            r.clock = 1'b1;
            if (shift_pos >= SHIFT_BITS) begin
                shift_pos = '0;
                for (int p = 0; p < PADS; p++) pad_rdy[p] = 1'b1;
            end else begin
                shift_pos = shift_pos + 1'b1;
            end
        end
        if (t.enumerated) begin
            if (tick_cnt <= poll_ivl) begin
                tick_cnt = tick_cnt + 1'b1;
            end else begin
                tick_cnt = '0;
                for (int p = 0; p < PADS; p++) begin
                    pad_btn[p] = '0;
                    pad_rdy[p] = 1'b0;
                end
                r.latch   = 1'b1;
                shift_pos = 4'd1;
            end
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Tick driver: hold the payload while stalled, idle now and then, and
    // keep a paused tick back until the block has drained
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_ticks
        bit took;
        bit go;
        if (i_rst_n) begin
            took = i_in_valid && !o_in_stall;
            if (took) begin
                due_results.push_back(poll_tick(cur_tick));
                ticks_sent <= ticks_sent + 1;
            end
            if (!i_in_valid || took) begin
                go = 1'b0;
                if (tick_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    go = !tick_q[0].after_drain || (!took && ticks_sent == results_done);
                end
                if (go) begin
                    cur_tick           = tick_q.pop_front();
                    i_enumerated       <= cur_tick.enumerated;
                    i_endpoint_free    <= cur_tick.endpoint_free;
                    i_first_pad_level  <= cur_tick.first_level;
                    i_second_pad_level <= cur_tick.second_level;
                end
                i_in_valid <= go;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each transfer with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        gpr_pkg::t_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_done <= results_done + 1;
                if (due_results.size() == 0) begin
                    flag_mismatch("result transfer with no tick outstanding");
                end else begin
                    want = due_results.pop_front();
                    if (o_latch_pulse !== want.latch)
                        flag_mismatch($sformatf("result %0d: latch %b, want %b",
                                      results_done, o_latch_pulse, want.latch));
                    if (o_clock_pulse !== want.clock)
                        flag_mismatch($sformatf("result %0d: clock %b, want %b",
                                      results_done, o_clock_pulse, want.clock));
                    if (o_report_valid !== want.valid)
                        flag_mismatch($sformatf("result %0d: report valid %b, want %b",
                                      results_done, o_report_valid, want.valid));
                    if (o_report_id !== want.id)
                        flag_mismatch($sformatf("result %0d: report id %h, want %h",
                                      results_done, o_report_id, want.id));
                    if (o_report_buttons !== want.buttons)
                        flag_mismatch($sformatf("result %0d: buttons %h, want %h",
                                      results_done, o_report_buttons, want.buttons));
                end
            end
            i_out_stall <= (rx_hold_left != 0) ||
                           (!steady && $urandom_range(99) < IDLE_PCT);
        end
    end

    // Long receiver hold-off, counted here so the sender keeps offering
    always @(posedge i_clk) begin
        if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end else if (hold_asks != holds_done) begin
            rx_hold_left <= HOLD_CYCLES;
            holds_done   <= holds_done + 1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("gamepad_poll_and_report verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_tick(bit en, bit free, bit l0, bit l1, bit drain);
        t_tick t;
        t.enumerated    = en;
        t.endpoint_free = free;
        t.first_level   = l0;
        t.second_level  = l1;
        t.after_drain   = drain;
        tick_q.push_back(t);
    endfunction

    // Mostly enumerated ticks so the counter keeps moving; pause once if asked
    task automatic queue_random(input int n, input int pause_at);
        @(negedge i_clk);
        for (int k = 0; k < n; k++) begin
            queue_tick($urandom_range(99) < 85, $urandom_range(99) < 60,
                       1'($urandom_range(1)), 1'($urandom_range(1)), k == pause_at);
        end
    endtask

    // Sample at the falling edge so the driver's updates have settled
    task automatic wait_idle();
        do @(negedge i_clk);
        while (tick_q.size() != 0 || i_in_valid || ticks_sent > results_done);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [gpr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [gpr_pkg::CFG_DAT_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            gpr_pkg::CFG_POLL_INTERVAL: poll_ivl  = data;
            gpr_pkg::CFG_FIRST_ID:      pad_id[0] = data[gpr_pkg::ID_W-1:0];
            gpr_pkg::CFG_SECOND_ID:     pad_id[1] = data[gpr_pkg::ID_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [gpr_pkg::CFG_DAT_W-1:0] ivl,
                             input logic [gpr_pkg::CFG_DAT_W-1:0] first_id,
                             input logic [gpr_pkg::CFG_DAT_W-1:0] second_id);
        write_reg(gpr_pkg::CFG_POLL_INTERVAL, ivl);
        write_reg(gpr_pkg::CFG_FIRST_ID, first_id);
        write_reg(gpr_pkg::CFG_SECOND_ID, second_id);
    endtask

    // ------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------
    initial begin : run_phases
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Shortest interval; report ids stay at their reset values
        write_reg(gpr_pkg::CFG_POLL_INTERVAL, 16'd9);

        // Directed: idle tick, count up to the poll, shift with first pad
        // all pressed and second pad all released, a few shifts while not
        // enumerated, then busy endpoint, not enumerated, both sends, none.
        @(negedge i_clk);
        queue_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        for (int k = 0; k < 10; k++) queue_tick(1'b1, k[0], k[1], k[2], 1'b0);
        queue_tick(1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
        for (int k = 0; k < SHIFT_BITS; k++)
            queue_tick(k != 2 && k != 5, 1'b1, 1'b0, 1'b1, 1'b0);
        queue_tick(1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
        queue_tick(1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
        repeat (3) queue_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
        wait_idle();

        // Id extremes with junk in the upper data bits; poke a missing index
        configure(16'd9, 16'hFF00, 16'h00FF);
        write_reg(CFG_IDX_UNUSED, 16'hFFFF);
        queue_random(200, 100);
        wait_idle();

        // Short random interval; receiver holds off while ticks keep coming
        configure(16'($urandom_range(40, 10)), 16'($urandom_range(16'hFFFF)),
                  16'($urandom_range(16'hFFFF)));
        queue_random(200, -1);
        hold_asks++;
        wait_idle();

        // Widest interval: the counter never passes it, so no poll starts
        configure(16'hFFFF, 16'($urandom_range(16'hFFFF)),
                  16'($urandom_range(16'hFFFF)));
        queue_random(150, -1);
        wait_idle();

        // Back to the shortest: the counter is already past it, poll at once.
        // Run this phase flat out on both sides.
        configure(16'd9, 16'($urandom_range(16'hFFFF)),
                  16'($urandom_range(16'hFFFF)));
        steady = 1'b1;
        queue_random(250, -1);
        wait_idle();
        steady = 1'b0;

        // Ids swapped to the other extremes; another hold-off and a pause
        configure(16'($urandom_range(30, 9)), 16'h00FF, 16'h0000);
        queue_random(250, 60);
        hold_asks++;
        wait_idle();

        if (mismatches == 0) begin
            $display("gamepad_poll_and_report verification clean");
        end else begin
            $display("gamepad_poll_and_report verification failed");
        end
        $finish;
    end

endmodule
